// ----- design/lob_pkg.sv -----
package lob_pkg;

  localparam int MAX_ORDERS_DEF = 64;
  localparam int IDX_W   = 6;
  localparam int OP_W    = 2;
  localparam int QTY_W   = 17;
  localparam int PRC_W   = 17;
  localparam int TGT_W   = 7;
  localparam int SUM_W   = 23;
  localparam int TRN_W   = 6;
  localparam logic [PRC_W-1:0] NO_ASK_PRICE = PRC_W'(99999);
  localparam logic [TRN_W-1:0] MAX_TRADES   = TRN_W'(63);

  localparam logic [OP_W-1:0] OP_BUY  = 2'd0;
  localparam logic [OP_W-1:0] OP_SELL = 2'd1;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_QUOTE = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             bv;
    logic [IDX_W-1:0] bidx;
    logic [PRC_W-1:0] bprc;
    logic [QTY_W-1:0] bsz;
    logic [SUM_W-1:0] bsum;
    logic             av;
    logic [IDX_W-1:0] aidx;
    logic [PRC_W-1:0] aprc;
    logic [QTY_W-1:0] asz;
    logic [SUM_W-1:0] asum;
  } cand_t;

  typedef struct packed {
    logic             ld;
    logic [IDX_W-1:0] ld_idx;
    logic             ld_act;
    logic             ld_side;
    logic [PRC_W-1:0] ld_prc;
    logic [QTY_W-1:0] ld_sz;
    logic             cx;
    logic [IDX_W-1:0] cx_idx;
    logic             tr;
    logic [IDX_W-1:0] tr_bidx;
    logic [IDX_W-1:0] tr_aidx;
    logic [QTY_W-1:0] tr_sz;
  } cmd_t;

endpackage

// ----- design/lob_in_if.sv -----
interface lob_in_if;
  logic                        valid;
  logic                        ready;
  logic [lob_pkg::OP_W-1:0]    operation;
  logic [lob_pkg::QTY_W-1:0]   quantity;
  logic [lob_pkg::PRC_W-1:0]   limit_price;
  logic [lob_pkg::TGT_W-1:0]   cancel_target;

  modport source (output valid, operation, quantity, limit_price, cancel_target,
                  input ready);
  modport sink (input valid, operation, quantity, limit_price, cancel_target,
                output ready);
endinterface

// ----- design/lob_out_if.sv -----
interface lob_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lob_pkg::QTY_W-1:0]   trade_size;
  logic [lob_pkg::PRC_W-1:0]   trade_price;
  logic [lob_pkg::SUM_W-1:0]   bid_size;
  logic [lob_pkg::PRC_W-1:0]   bid_price;
  logic [lob_pkg::SUM_W-1:0]   ask_size;
  logic [lob_pkg::PRC_W-1:0]   ask_price;
  logic                        rejected;
  logic                        last;

  modport source (output valid, kind, trade_size, trade_price, bid_size, bid_price,
                  ask_size, ask_price, rejected, last, input ready);
  modport sink (input valid, kind, trade_size, trade_price, bid_size, bid_price,
                ask_size, ask_price, rejected, last, output ready);
endinterface

// ----- design/lob_cell.sv -----
module lob_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lob_pkg::cmd_t  cmd,
  input  lob_pkg::cand_t c_in,
  output lob_pkg::cand_t c_out
);
  import lob_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             act_r, act_nxt;
  logic             side_r, side_nxt;
  logic [PRC_W-1:0] prc_r, prc_nxt;
  logic [QTY_W-1:0] sz_r, sz_nxt;
  cand_t            c_r, c_nxt;

  always_comb begin
    act_nxt  = act_r;
    side_nxt = side_r;
    prc_nxt  = prc_r;
    sz_nxt   = sz_r;
    if (cmd.ld && cmd.ld_idx == MY_IDX) begin
      act_nxt  = cmd.ld_act;
      side_nxt = cmd.ld_side;
      prc_nxt  = cmd.ld_prc;
      sz_nxt   = cmd.ld_sz;
    end
    if (cmd.cx && cmd.cx_idx == MY_IDX) begin
      act_nxt = 1'b0;
      sz_nxt  = '0;
    end
    if (cmd.tr && (cmd.tr_bidx == MY_IDX || cmd.tr_aidx == MY_IDX)) begin
      sz_nxt = sz_r - cmd.tr_sz;
      if (sz_nxt == '0) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    c_nxt = c_in;
    if (act_r && !side_r) begin
      if (!c_in.bv || prc_r > c_in.bprc) begin
        c_nxt.bv   = 1'b1;
        c_nxt.bidx = MY_IDX;
        c_nxt.bprc = prc_r;
        c_nxt.bsz  = sz_r;
        c_nxt.bsum = SUM_W'(sz_r);
      end else if (prc_r == c_in.bprc) begin
        c_nxt.bsum = c_in.bsum + SUM_W'(sz_r);
      end
    end
    if (act_r && side_r) begin
      if (!c_in.av || prc_r < c_in.aprc) begin
        c_nxt.av   = 1'b1;
        c_nxt.aidx = MY_IDX;
        c_nxt.aprc = prc_r;
        c_nxt.asz  = sz_r;
        c_nxt.asum = SUM_W'(sz_r);
      end else if (prc_r == c_in.aprc) begin
        c_nxt.asum = c_in.asum + SUM_W'(sz_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      sz_r    <= '0;
      c_r.vld <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      sz_r    <= sz_nxt;
      c_r.vld <= c_nxt.vld;
    end
    side_r <= side_nxt;
    prc_r  <= prc_nxt;
    c_r.bv   <= c_nxt.bv;
    c_r.bidx <= c_nxt.bidx;
    c_r.bprc <= c_nxt.bprc;
    c_r.bsz  <= c_nxt.bsz;
    c_r.bsum <= c_nxt.bsum;
    c_r.av   <= c_nxt.av;
    c_r.aidx <= c_nxt.aidx;
    c_r.aprc <= c_nxt.aprc;
    c_r.asz  <= c_nxt.asz;
    c_r.asum <= c_nxt.asum;
  end

  assign c_out = c_r;

endmodule

// ----- design/limit_order_book_matcher.sv -----
// Limit order book matcher with price-time priority.
// in_ch carries buy, sell and cancel requests; an item is taken when valid
// and ready are both high. out_ch returns zero or more trade items followed
// by one quote item flagged last. Only one request is worked on at a time:
// ready is high only while the block is idle.
// Orders live in a row of MAX_ORDERS cells, 64 by default. Each search for
// the best bid and ask sends a token down the row, one cell per cycle. A
// request with T trades runs T + 1 searches, and each search ends in one
// out_ch item. When out_ch.ready is low the pending item is held and the
// next search does not start until that item is taken.
// Reset (rst_n low, synchronous) empties the book and restarts the request
// numbering; once MAX_ORDERS requests are taken, each further request gets
// a quote only, with rejected set.
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lob_in_if.sink    in_ch,
  lob_out_if.source out_ch
);
  import lob_pkg::*;

  localparam int CNT_W = $clog2(MAX_ORDERS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt, after_r, after_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TRN_W-1:0] ntr_r, ntr_nxt;
  logic             rej_r, rej_nxt;
  logic             ovld_r, ovld_nxt;
  logic             okind_r, okind_nxt;
  logic [QTY_W-1:0] otsz_r, otsz_nxt;
  logic [PRC_W-1:0] otpr_r, otpr_nxt;
  logic [SUM_W-1:0] obsz_r, obsz_nxt, oasz_r, oasz_nxt;
  logic [PRC_W-1:0] obpr_r, obpr_nxt, oapr_r, oapr_nxt;
  logic             orej_r, orej_nxt;

  cmd_t  cmd;
  cand_t chain [0:MAX_ORDERS];
  cand_t res;
  logic  acc, tgt_ok;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign res = chain[MAX_ORDERS];
  assign tgt_ok = (in_ch.cancel_target != '0) &&
                  (32'(in_ch.cancel_target) <= MAX_ORDERS);

  always_comb begin
    chain[0]     = '0;
    chain[0].vld = (state_r == S_SCAN);
  end

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lob_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .c_in  (chain[g]),
      .c_out (chain[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    cnt_nxt   = cnt_r;
    ntr_nxt   = ntr_r;
    rej_nxt   = rej_r;
    ovld_nxt  = ovld_r;
    okind_nxt = okind_r;
    otsz_nxt  = otsz_r;
    otpr_nxt  = otpr_r;
    obsz_nxt  = obsz_r;
    obpr_nxt  = obpr_r;
    oasz_nxt  = oasz_r;
    oapr_nxt  = oapr_r;
    orej_nxt  = orej_r;
    cmd         = '0;
    cmd.ld_idx  = IDX_W'(cnt_r);
    cmd.ld_act  = !in_ch.operation[1] && (in_ch.quantity != '0);
    cmd.ld_side = in_ch.operation[0];
    cmd.ld_prc  = in_ch.limit_price;
    cmd.ld_sz   = in_ch.quantity;
    cmd.cx_idx  = IDX_W'(in_ch.cancel_target - TGT_W'(1));
    cmd.tr_bidx = res.bidx;
    cmd.tr_aidx = res.aidx;
    cmd.tr_sz   = (res.bsz < res.asz) ? res.bsz : res.asz;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          rej_nxt   = (cnt_r >= CNT_W'(MAX_ORDERS));
          ntr_nxt   = '0;
          state_nxt = S_SCAN;
          if (!rej_nxt) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            cmd.ld  = 1'b1;
            cmd.cx  = in_ch.operation[1] && tgt_ok;
          end
        end
      end
      S_SCAN: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (res.vld) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_OUT;
          orej_nxt  = 1'b0;
          if (!rej_r && ntr_r < MAX_TRADES && res.bv && res.av &&
              res.bprc >= res.aprc) begin
            cmd.tr    = 1'b1;
            ntr_nxt   = ntr_r + TRN_W'(1);
            okind_nxt = KIND_TRADE;
            otsz_nxt  = cmd.tr_sz;
            otpr_nxt  = (res.bidx < res.aidx) ? res.bprc : res.aprc;
            obsz_nxt  = '0;
            obpr_nxt  = '0;
            oasz_nxt  = '0;
            oapr_nxt  = '0;
            after_nxt = S_SCAN;
          end else begin
            okind_nxt = KIND_QUOTE;
            otsz_nxt  = '0;
            otpr_nxt  = '0;
            obsz_nxt  = res.bv ? res.bsum : '0;
            obpr_nxt  = res.bv ? res.bprc : '0;
            oasz_nxt  = res.av ? res.asum : '0;
            oapr_nxt  = res.av ? res.aprc : NO_ASK_PRICE;
            orej_nxt  = rej_r;
            after_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          ovld_nxt  = 1'b0;
          state_nxt = after_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      cnt_r   <= '0;
      ntr_r   <= '0;
      rej_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      cnt_r   <= cnt_nxt;
      ntr_r   <= ntr_nxt;
      rej_r   <= rej_nxt;
      ovld_r  <= ovld_nxt;
    end
    okind_r <= okind_nxt;
    otsz_r  <= otsz_nxt;
    otpr_r  <= otpr_nxt;
    obsz_r  <= obsz_nxt;
    obpr_r  <= obpr_nxt;
    oasz_r  <= oasz_nxt;
    oapr_r  <= oapr_nxt;
    orej_r  <= orej_nxt;
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.kind        = okind_r;
  assign out_ch.trade_size  = otsz_r;
  assign out_ch.trade_price = otpr_r;
  assign out_ch.bid_size    = obsz_r;
  assign out_ch.bid_price   = obpr_r;
  assign out_ch.ask_size    = oasz_r;
  assign out_ch.ask_price   = oapr_r;
  assign out_ch.rejected    = orej_r;
  assign out_ch.last        = okind_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ORDERS)) else $error("request count beyond table");

  a_token_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> state_r == S_WAIT) else $error("search token outside wait");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r == (state_r == S_OUT)) else $error("output valid out of step");

  a_rej_notrade: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && rej_r) |-> okind_r == KIND_QUOTE) else $error("trade on rejected item");

endmodule
